>>> src/bmd_pkg.sv
package bmd_pkg;

   localparam int BMD_ADDR_W = 4;
   localparam int BMD_DATA_W = 32;
   localparam int BMD_THR_W = 15;
   localparam int BMD_AXES = 3;

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_GAIN      = 2'd1,
      CSR_SCALE     = 2'd2,
      CSR_MAX_DUTY  = 2'd3
   } bmd_csr_idx_type;

   localparam logic [14:0] RST_THRESHOLD = 15'd1000;
   localparam logic [15:0] RST_GAIN = 16'd256;
   localparam logic [15:0] RST_SCALE = 16'd256;
   localparam logic [7:0] RST_MAX_DUTY = 8'd100;

   typedef struct packed {
      logic [BMD_THR_W-1:0] threshold;
      logic [15:0] gain;
      logic [15:0] duty_scale;
      logic [7:0] max_duty;
   } bmd_cfg_type;

   typedef struct packed {
      logic [15:0] roll_angle;
      logic [15:0] pitch_angle;
      logic [15:0] yaw_angle;
      logic [15:0] rate_p;
      logic [15:0] rate_q;
      logic [15:0] rate_r;
      logic [15:0] field_x;
      logic [15:0] field_y;
      logic [15:0] field_z;
   } bmd_sample_type;

   // magnitude of the negative part of dB per body axis, zero where dB >= 0
   typedef struct packed {
      logic en;
      logic [BMD_AXES-1:0][31:0] mag;
   } bmd_mag_type;

   typedef struct packed {
      logic en;
      logic [BMD_AXES-1:0][7:0] duty;
   } bmd_duty_type;

   function automatic logic [15:0] bmd_abs16(input logic [15:0] a);
      return a[15] ? 16'(-a) : a;
   endfunction

endpackage

>>> src/bmd_req_if.sv
interface bmd_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   logic signed [15:0] rate_p;
   logic signed [15:0] rate_q;
   logic signed [15:0] rate_r;
   logic signed [15:0] field_x;
   logic signed [15:0] field_y;
   logic signed [15:0] field_z;

   modport source (
      output valid, roll_angle, pitch_angle, yaw_angle, rate_p, rate_q, rate_r,
             field_x, field_y, field_z,
      input ready
   );
   modport sink (
      input valid, roll_angle, pitch_angle, yaw_angle, rate_p, rate_q, rate_r,
            field_x, field_y, field_z,
      output ready
   );
endinterface

>>> src/bmd_rsp_if.sv
interface bmd_rsp_if;
   logic valid;
   logic ready;
   logic coil_enable;
   logic [7:0] duty_body_x;
   logic [7:0] duty_body_y;
   logic [7:0] duty_body_z;

   modport source (
      output valid, coil_enable, duty_body_x, duty_body_y, duty_body_z,
      input ready
   );
   modport sink (
      input valid, coil_enable, duty_body_x, duty_body_y, duty_body_z,
      output ready
   );
endinterface

>>> src/bmd_csr.sv
module bmd_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [bmd_pkg::BMD_ADDR_W-1:0] csr_paddr,
   input  logic [bmd_pkg::BMD_DATA_W-1:0] csr_pwdata,
   output logic [bmd_pkg::BMD_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output bmd_pkg::bmd_cfg_type cfg
);
   import bmd_pkg::*;

   bmd_cfg_type cfg_ff, cfg_in;
   bmd_csr_idx_type idx;
   logic wr;

   assign idx = bmd_csr_idx_type'(csr_paddr[3:2]);
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            CSR_THRESHOLD: cfg_in.threshold = csr_pwdata[BMD_THR_W-1:0];
            CSR_GAIN:      cfg_in.gain = csr_pwdata[15:0];
            CSR_SCALE:     cfg_in.duty_scale = csr_pwdata[15:0];
            CSR_MAX_DUTY:  cfg_in.max_duty = csr_pwdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_THRESHOLD: csr_prdata = BMD_DATA_W'(cfg_ff.threshold);
         CSR_GAIN:      csr_prdata = BMD_DATA_W'(cfg_ff.gain);
         CSR_SCALE:     csr_prdata = BMD_DATA_W'(cfg_ff.duty_scale);
         CSR_MAX_DUTY:  csr_prdata = BMD_DATA_W'(cfg_ff.max_duty);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= RST_THRESHOLD;
         cfg_ff.gain <= RST_GAIN;
         cfg_ff.duty_scale <= RST_SCALE;
         cfg_ff.max_duty <= RST_MAX_DUTY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/bmd_cross.sv
module bmd_cross (
   input  logic clock,
   input  logic reset,
   input  bmd_pkg::bmd_cfg_type cfg,
   input  logic in_valid,
   output logic in_ready,
   input  bmd_pkg::bmd_sample_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output bmd_pkg::bmd_mag_type out_data
);
   import bmd_pkg::*;

   // body frame: W = (-r, -q, p), B = (fz, fy, -fx)
   logic signed [16:0] wx, wy, wz, bx, by, bz;
   logic signed [33:0] prod_in [6];
   logic signed [33:0] prod_ff [6];
   logic en_in, s1_en_ff;
   logic s1_valid_ff, s2_valid_ff;
   logic s1_adv, s2_adv;
   logic [15:0] thr16;
   logic [34:0] diff [BMD_AXES];
   logic [34:0] diff_neg [BMD_AXES];
   bmd_mag_type mag_in, mag_ff;

   assign s2_adv = !s2_valid_ff || out_ready;
   assign s1_adv = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;
   assign out_valid = s2_valid_ff;
   assign out_data = mag_ff;

   always_comb begin
      wx = -$signed({in_data.rate_r[15], in_data.rate_r});
      wy = -$signed({in_data.rate_q[15], in_data.rate_q});
      wz = $signed({in_data.rate_p[15], in_data.rate_p});
      bx = $signed({in_data.field_z[15], in_data.field_z});
      by = $signed({in_data.field_y[15], in_data.field_y});
      bz = -$signed({in_data.field_x[15], in_data.field_x});
      prod_in[0] = wy * bz;
      prod_in[1] = wz * by;
      prod_in[2] = wz * bx;
      prod_in[3] = wx * bz;
      prod_in[4] = wx * by;
      prod_in[5] = wy * bx;
   end

   assign thr16 = {1'b0, cfg.threshold};
   assign en_in = (bmd_abs16(in_data.roll_angle) > thr16)
               || (bmd_abs16(in_data.pitch_angle) > thr16)
               || (bmd_abs16(in_data.yaw_angle) > thr16);

   always_comb begin
      mag_in.en = s1_en_ff;
      for (int k = 0; k < BMD_AXES; k++) begin
         diff[k] = {prod_ff[2*k][33], prod_ff[2*k]}
                 - {prod_ff[2*k+1][33], prod_ff[2*k+1]};
         diff_neg[k] = -diff[k];
         // |dB| never exceeds 2^31, so 32 bits hold it
         mag_in.mag[k] = diff[k][34] ? diff_neg[k][31:0] : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= in_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
      end
      if (s1_adv && in_valid) begin
         for (int k = 0; k < 6; k++) prod_ff[k] <= prod_in[k];
         s1_en_ff <= en_in;
      end
      if (s2_adv && s1_valid_ff) mag_ff <= mag_in;
   end

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_adv |=> s1_valid_ff && $stable(s1_en_ff)
                                && $stable(prod_ff[0]) && $stable(prod_ff[5]))
      else $error("stalled first stage lost its beat");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> mag_ff.mag[0] <= 32'h8000_0000
                   && mag_ff.mag[1] <= 32'h8000_0000
                   && mag_ff.mag[2] <= 32'h8000_0000)
      else $error("dB magnitude out of range");

endmodule

>>> src/bmd_scale.sv
module bmd_scale (
   input  logic clock,
   input  logic reset,
   input  bmd_pkg::bmd_cfg_type cfg,
   input  logic in_valid,
   output logic in_ready,
   input  bmd_pkg::bmd_mag_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output bmd_pkg::bmd_duty_type out_data
);
   import bmd_pkg::*;

   logic s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s3_adv, s4_adv, s5_adv;
   logic s3_en_ff, s4_en_ff;
   logic [47:0] q_in [BMD_AXES];
   logic [47:0] q_ff [BMD_AXES];
   logic [63:0] r_in [BMD_AXES];
   logic [63:0] r_ff [BMD_AXES];
   bmd_duty_type duty_in, duty_ff;

   assign s5_adv = !s5_valid_ff || out_ready;
   assign s4_adv = !s4_valid_ff || s5_adv;
   assign s3_adv = !s3_valid_ff || s4_adv;
   assign in_ready = s3_adv;
   assign out_valid = s5_valid_ff;
   assign out_data = duty_ff;

   always_comb begin
      for (int k = 0; k < BMD_AXES; k++) begin
         q_in[k] = 48'(in_data.mag[k]) * 48'(cfg.gain);
         r_in[k] = 64'(q_ff[k]) * 64'(cfg.duty_scale);
      end
   end

   // drop 24 fraction bits, saturate at max_duty, force zero while coils are disabled
   always_comb begin
      duty_in.en = s4_en_ff;
      for (int k = 0; k < BMD_AXES; k++) begin
         if (!s4_en_ff) begin
            duty_in.duty[k] = 8'd0;
         end else if ((|r_ff[k][63:32]) || (r_ff[k][31:24] > cfg.max_duty)) begin
            duty_in.duty[k] = cfg.max_duty;
         end else begin
            duty_in.duty[k] = r_ff[k][31:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s3_adv) s3_valid_ff <= in_valid;
         if (s4_adv) s4_valid_ff <= s3_valid_ff;
         if (s5_adv) s5_valid_ff <= s4_valid_ff;
      end
      if (s3_adv && in_valid) begin
         for (int k = 0; k < BMD_AXES; k++) q_ff[k] <= q_in[k];
         s3_en_ff <= in_data.en;
      end
      if (s4_adv && s3_valid_ff) begin
         for (int k = 0; k < BMD_AXES; k++) r_ff[k] <= r_in[k];
         s4_en_ff <= s3_en_ff;
      end
      if (s5_adv && s4_valid_ff) duty_ff <= duty_in;
   end

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && !duty_ff.en |-> duty_ff.duty == '0)
      else $error("duty nonzero with coils disabled");

   a_s4_hold: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !s5_adv |=> s4_valid_ff && $stable(s4_en_ff)
                                && $stable(r_ff[0]) && $stable(r_ff[2]))
      else $error("stalled product stage lost its beat");

endmodule

>>> src/bdot_magnetorquer_duty.sv
// B-dot magnetorquer duty controller. Each beat on req_chan carries three attitude
// angles, three body rates and three magnetometer axes; rsp_chan returns one beat
// per sample with coil_enable and three clamped duties. Throughput is one sample
// per clock while rsp_chan does not stall. There are five register stages:
// products, cross-product difference, gain multiply, scale multiply and clamp.
// Stalls on rsp_chan back up stage by stage, so empty stages still take new
// samples. Registers sit on the csr_ port at byte addresses 0, 4, 8, 12:
// angle_threshold, gain (Q8.8), duty_scale (Q0.16), max_duty; write them only while
// no sample is in flight.
module bdot_magnetorquer_duty (
   input  logic clock,
   input  logic reset,
   bmd_req_if.sink req_chan,
   bmd_rsp_if.source rsp_chan,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [bmd_pkg::BMD_ADDR_W-1:0] csr_paddr,
   input  logic [bmd_pkg::BMD_DATA_W-1:0] csr_pwdata,
   output logic [bmd_pkg::BMD_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import bmd_pkg::*;

   bmd_cfg_type cfg;
   bmd_sample_type sample;
   bmd_mag_type mag;
   bmd_duty_type duty;
   logic mag_valid, mag_ready;

   assign sample.roll_angle = req_chan.roll_angle;
   assign sample.pitch_angle = req_chan.pitch_angle;
   assign sample.yaw_angle = req_chan.yaw_angle;
   assign sample.rate_p = req_chan.rate_p;
   assign sample.rate_q = req_chan.rate_q;
   assign sample.rate_r = req_chan.rate_r;
   assign sample.field_x = req_chan.field_x;
   assign sample.field_y = req_chan.field_y;
   assign sample.field_z = req_chan.field_z;

   bmd_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   bmd_cross u_cross (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .in_valid(req_chan.valid),
      .in_ready(req_chan.ready),
      .in_data(sample),
      .out_valid(mag_valid),
      .out_ready(mag_ready),
      .out_data(mag)
   );

   bmd_scale u_scale (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .in_valid(mag_valid),
      .in_ready(mag_ready),
      .in_data(mag),
      .out_valid(rsp_chan.valid),
      .out_ready(rsp_chan.ready),
      .out_data(duty)
   );

   assign rsp_chan.coil_enable = duty.en;
   assign rsp_chan.duty_body_x = duty.duty[0];
   assign rsp_chan.duty_body_y = duty.duty[1];
   assign rsp_chan.duty_body_z = duty.duty[2];

endmodule
